@@ src/cma_pkg.sv @@
// Shared types and constants for the centered moving average block.
// Used by the top level, the front end, the back end and the checker; has no dependencies of its own.
`default_nettype none

package cma_pkg;

    // Fixed widths of the ports.
    localparam int DATA_W = 32;
    localparam int CFG_W  = 5;

    // Largest radius that the configuration register can hold.
    localparam int MAX_CFG_RADIUS = (1 << CFG_W) - 1;

    // Defaults for the top level parameters.
    localparam int DEF_MAX_RADIUS   = 31;
    localparam int DEF_SAMPLE_WIDTH = 32;

    // Depth of the command queue between the front and back ends.
    localparam int QUEUE_DEPTH = 2;

    typedef enum logic [0:0] {
        F_IDLE,
        F_UPDATE
    } t_front_state;

    typedef enum logic [1:0] {
        B_IDLE,
        B_DIVIDE,
        B_FIRST,
        B_TRAIL
    } t_back_state;

    // Control flags of one command handed from the front end to the back end.
    typedef struct packed {
        logic first_vld;   // the item produces a result for a centre
        logic first_full;  // that centre had a full window
        logic first_done;  // that result is the last of the stream
    } t_cmd_flags;

endpackage

`default_nettype wire

@@ src/centered_moving_average.sv @@
// Centered moving average: a new sample is taken only once the previous one has updated the
// window sum; each full-window sample then holds the bit-serial divider in the back end.
// Results for centres without a full window, and the trailing ones at stream end, skip the divider.
// Reset is synchronous, active low, and clears the control state and the radius;
// the delay line RAM is not cleared, since an entry read before it is written is not used.
`default_nettype none

module centered_moving_average #(
    parameter int MAX_RADIUS   = cma_pkg::DEF_MAX_RADIUS,
    parameter int SAMPLE_WIDTH = cma_pkg::DEF_SAMPLE_WIDTH
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_in_valid,
    output logic                            o_in_ready,
    input  wire logic [cma_pkg::DATA_W-1:0] i_sample,
    input  wire logic                       i_end_of_stream,
    output logic                            o_out_valid,
    input  wire logic                       i_out_ready,
    output logic [cma_pkg::DATA_W-1:0]      o_average,
    output logic                            o_window_full,
    output logic                            o_stream_done,
    input  wire logic                       i_cfg_valid,
    output logic                            o_cfg_ready,
    input  wire logic [cma_pkg::CFG_W-1:0]  i_cfg_data
);

    localparam int R_MAX    = (MAX_RADIUS < cma_pkg::MAX_CFG_RADIUS) ?
                              MAX_RADIUS : cma_pkg::MAX_CFG_RADIUS;
    localparam int SIZE_MAX = 2 * R_MAX + 1;
    localparam int AW       = $clog2(SIZE_MAX + 1);
    localparam int DEPTH    = 1 << AW;
    localparam int SW       = SAMPLE_WIDTH;
    localparam int TW       = SW + AW;
    localparam int FW       = $bits(cma_pkg::t_cmd_flags);
    localparam int CMD_W    = TW + AW + AW + FW;

    logic                 w_ram_we;
    logic [AW-1:0]        w_ram_waddr;
    logic [SW-1:0]        w_ram_wdata;
    logic                 w_ram_re;
    logic [AW-1:0]        w_ram_raddr;
    logic [SW-1:0]        w_ram_rdata;

    logic                 w_push;
    logic                 w_full;
    logic                 w_pop;
    logic                 w_cmd_valid;
    logic [CMD_W-1:0]     w_push_data;
    logic [CMD_W-1:0]     w_pop_data;

    logic signed [TW-1:0] w_f_total;
    logic [AW-1:0]        w_f_size;
    logic [AW-1:0]        w_f_trail;
    cma_pkg::t_cmd_flags  w_f_flags;

    logic signed [TW-1:0] w_b_total;
    logic [AW-1:0]        w_b_size;
    logic [AW-1:0]        w_b_trail;
    cma_pkg::t_cmd_flags  w_b_flags;

    cma_front #(
        .AW    (AW),
        .SW    (SW),
        .TW    (TW),
        .R_MAX (R_MAX)
    ) u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_sample        (i_sample),
        .i_end_of_stream (i_end_of_stream),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_data      (i_cfg_data),
        .o_ram_we        (w_ram_we),
        .o_ram_waddr     (w_ram_waddr),
        .o_ram_wdata     (w_ram_wdata),
        .o_ram_re        (w_ram_re),
        .o_ram_raddr     (w_ram_raddr),
        .i_ram_rdata     (w_ram_rdata),
        .o_push          (w_push),
        .i_full          (w_full),
        .o_cmd_total     (w_f_total),
        .o_cmd_size      (w_f_size),
        .o_cmd_trail     (w_f_trail),
        .o_cmd_flags     (w_f_flags)
    );

    cma_ram #(
        .WIDTH (SW),
        .DEPTH (DEPTH)
    ) u_delay_line (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (w_ram_waddr),
        .i_wdata (w_ram_wdata),
        .i_re    (w_ram_re),
        .i_raddr (w_ram_raddr),
        .o_rdata (w_ram_rdata)
    );

    assign w_push_data = {w_f_total, w_f_size, w_f_trail, w_f_flags};

    cma_fifo #(
        .WIDTH (CMD_W),
        .DEPTH (cma_pkg::QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_push_data),
        .o_full  (w_full),
        .o_valid (w_cmd_valid),
        .i_pop   (w_pop),
        .o_data  (w_pop_data)
    );

    assign {w_b_total, w_b_size, w_b_trail, w_b_flags} = w_pop_data;

    cma_back #(
        .AW (AW),
        .SW (SW),
        .TW (TW)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd_valid   (w_cmd_valid),
        .o_pop         (w_pop),
        .i_cmd_total   (w_b_total),
        .i_cmd_size    (w_b_size),
        .i_cmd_trail   (w_b_trail),
        .i_cmd_flags   (w_b_flags),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_average     (o_average),
        .o_window_full (o_window_full),
        .o_stream_done (o_stream_done)
    );

endmodule

`default_nettype wire

@@ src/cma_ram.sv @@
// Generic single write port, single read port RAM with a registered read.
// No dependencies.
`default_nettype none

module cma_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

@@ src/cma_front.sv @@
// Front end: accepts samples and radius writes, keeps the delay line pointers
// and the running window sum, and turns each sample into a command word.
// Depends on cma_pkg; the delay line RAM sits outside, in the top level.
`default_nettype none

module cma_front #(
    parameter int AW    = 6,
    parameter int SW    = 32,
    parameter int TW    = 38,
    parameter int R_MAX = 31
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_in_valid,
    output logic                            o_in_ready,
    input  wire logic [cma_pkg::DATA_W-1:0] i_sample,
    input  wire logic                       i_end_of_stream,
    input  wire logic                       i_cfg_valid,
    output logic                            o_cfg_ready,
    input  wire logic [cma_pkg::CFG_W-1:0]  i_cfg_data,
    output logic                            o_ram_we,
    output logic      [AW-1:0]              o_ram_waddr,
    output logic      [SW-1:0]              o_ram_wdata,
    output logic                            o_ram_re,
    output logic      [AW-1:0]              o_ram_raddr,
    input  wire logic [SW-1:0]              i_ram_rdata,
    output logic                            o_push,
    input  wire logic                       i_full,
    output logic signed [TW-1:0]            o_cmd_total,
    output logic      [AW-1:0]              o_cmd_size,
    output logic      [AW-1:0]              o_cmd_trail,
    output cma_pkg::t_cmd_flags             o_cmd_flags
);

    localparam logic [AW-1:0] SEEN_MAX = '1;

    cma_pkg::t_front_state r_state, n_state;

    logic [cma_pkg::CFG_W-1:0] r_radius;
    logic [AW-1:0]             r_wp;
    logic [AW-1:0]             r_seen;
    logic [AW-1:0]             r_j;
    logic signed [TW-1:0]      r_total;
    logic signed [SW-1:0]      r_x;
    logic                      r_last;

    logic [AW-1:0]        w_r;
    logic [AW-1:0]        w_size;
    logic [AW-1:0]        w_two_r;
    logic                 w_accept;
    logic                 w_cfg;
    logic                 w_need_push;
    logic                 w_upd_done;
    logic signed [SW-1:0] w_old;
    logic signed [TW-1:0] w_old_ext;
    logic signed [TW-1:0] w_new_total;

    // Radius in use, saturated to the largest one the delay line supports.
    always_comb begin
        if (int'(r_radius) > R_MAX) begin
            w_r = AW'(R_MAX);
        end else begin
            w_r = AW'(r_radius);
        end
        w_size  = {w_r[AW-2:0], 1'b1};
        w_two_r = {w_r[AW-2:0], 1'b0};
    end

    assign o_cfg_ready = (r_state == cma_pkg::F_IDLE);
    assign o_in_ready  = (r_state == cma_pkg::F_IDLE) && !i_cfg_valid;
    assign w_accept    = i_in_valid && o_in_ready;
    assign w_cfg       = i_cfg_valid && o_cfg_ready;

    // The sample leaving the window is read in the same cycle that the new one is written.
    assign o_ram_we    = w_accept;
    assign o_ram_waddr = r_wp;
    assign o_ram_wdata = i_sample[SW-1:0];
    assign o_ram_re    = w_accept;
    assign o_ram_raddr = r_wp - w_size;

    assign w_old = i_ram_rdata;

    always_comb begin
        if (r_j >= w_size) begin
            w_old_ext = TW'(w_old);
        end else begin
            w_old_ext = '0;
        end
        w_new_total = r_total - w_old_ext + TW'(r_x);
    end

    always_comb begin
        o_cmd_flags.first_vld  = (r_j >= w_r);
        o_cmd_flags.first_full = (r_j >= w_two_r);
        o_cmd_flags.first_done = r_last && (w_r == '0);
        if (!r_last) begin
            o_cmd_trail = '0;
        end else if (r_j >= w_r) begin
            o_cmd_trail = w_r;
        end else begin
            o_cmd_trail = r_j + 1'b1;
        end
    end

    assign o_cmd_total = w_new_total;
    assign o_cmd_size  = w_size;

    assign w_need_push = o_cmd_flags.first_vld || r_last;

    always_comb begin
        n_state    = r_state;
        o_push     = 1'b0;
        w_upd_done = 1'b0;
        case (r_state)
            cma_pkg::F_IDLE: begin
                if (w_accept) begin
                    n_state = cma_pkg::F_UPDATE;
                end
            end
            cma_pkg::F_UPDATE: begin
                if (!w_need_push || !i_full) begin
                    o_push     = w_need_push;
                    w_upd_done = 1'b1;
                    n_state    = cma_pkg::F_IDLE;
                end
            end
            default: begin
                n_state = cma_pkg::F_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= cma_pkg::F_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radius <= '0;
            r_total  <= '0;
            r_wp     <= '0;
            r_seen   <= '0;
        end else if (w_cfg) begin
            r_radius <= i_cfg_data;
            r_total  <= '0;
            r_wp     <= '0;
            r_seen   <= '0;
        end else if (w_accept) begin
            r_wp <= r_wp + 1'b1;
            if (r_seen != SEEN_MAX) begin
                r_seen <= r_seen + 1'b1;
            end
        end else if (w_upd_done) begin
            if (r_last) begin
                r_total <= '0;
                r_wp    <= '0;
                r_seen  <= '0;
            end else begin
                r_total <= w_new_total;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_x    <= i_sample[SW-1:0];
            r_last <= i_end_of_stream;
            r_j    <= r_seen;
        end
    end

endmodule

`default_nettype wire

@@ src/cma_fifo.sv @@
// Short command queue between the front end and the back end.
// No dependencies; DEPTH must be a power of two.
`default_nettype none

module cma_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic [WIDTH-1:0] i_data,
    output logic                  o_full,
    output logic                  o_valid,
    input  wire logic             i_pop,
    output logic      [WIDTH-1:0] o_data
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wr_ptr;
    logic [PW-1:0]    r_rd_ptr;
    logic [CW-1:0]    r_count;
    logic             w_push;
    logic             w_pop;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + 1'b1;
            end else if (w_pop && !w_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

`default_nettype wire

@@ src/cma_back.sv @@
// Back end: takes commands from the queue, divides the window sum with a
// one-bit-per-cycle restoring divider and drives the result output register.
// Depends on cma_pkg.
`default_nettype none

module cma_back #(
    parameter int AW = 6,
    parameter int SW = 32,
    parameter int TW = 38
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_cmd_valid,
    output logic                            o_pop,
    input  wire logic signed [TW-1:0]       i_cmd_total,
    input  wire logic [AW-1:0]              i_cmd_size,
    input  wire logic [AW-1:0]              i_cmd_trail,
    input  wire cma_pkg::t_cmd_flags        i_cmd_flags,
    output logic                            o_out_valid,
    input  wire logic                       i_out_ready,
    output logic [cma_pkg::DATA_W-1:0]      o_average,
    output logic                            o_window_full,
    output logic                            o_stream_done
);

    localparam int CW = $clog2(TW + 1);

    cma_pkg::t_back_state r_state, n_state;

    logic                 r_neg;
    logic [TW-1:0]        r_quo;
    logic [AW-1:0]        r_rem;
    logic [AW-1:0]        r_div;
    logic [CW-1:0]        r_cnt;
    logic [AW-1:0]        r_trail;
    cma_pkg::t_cmd_flags  r_flags;

    logic [AW:0]                 w_trial;
    logic                        w_ge;
    logic [AW:0]                 w_diff;
    logic [AW-1:0]               w_rem_next;
    logic [TW-1:0]               w_quo_signed;
    logic signed [SW-1:0]        w_avg_sw;
    logic                        w_can_load;
    logic                        w_emit;
    logic [cma_pkg::DATA_W-1:0]  w_emit_avg;
    logic                        w_emit_full;
    logic                        w_emit_done;

    // One restoring division step: bring down the next dividend bit.
    assign w_trial    = {r_rem, r_quo[TW-1]};
    assign w_ge       = (w_trial >= {1'b0, r_div});
    assign w_diff     = w_trial - {1'b0, r_div};
    assign w_rem_next = w_ge ? w_diff[AW-1:0] : w_trial[AW-1:0];

    // The quotient of the magnitude, negated back, truncates toward zero.
    assign w_quo_signed = r_neg ? (~r_quo + 1'b1) : r_quo;
    assign w_avg_sw     = w_quo_signed[SW-1:0];

    assign w_can_load = !o_out_valid || i_out_ready;

    always_comb begin
        n_state     = r_state;
        o_pop       = 1'b0;
        w_emit      = 1'b0;
        w_emit_avg  = '1;
        w_emit_full = 1'b0;
        w_emit_done = 1'b0;
        case (r_state)
            cma_pkg::B_IDLE: begin
                if (i_cmd_valid) begin
                    o_pop = 1'b1;
                    if (i_cmd_flags.first_vld && i_cmd_flags.first_full) begin
                        n_state = cma_pkg::B_DIVIDE;
                    end else if (i_cmd_flags.first_vld) begin
                        n_state = cma_pkg::B_FIRST;
                    end else begin
                        n_state = cma_pkg::B_TRAIL;
                    end
                end
            end
            cma_pkg::B_DIVIDE: begin
                if (r_cnt == CW'(1)) begin
                    n_state = cma_pkg::B_FIRST;
                end
            end
            cma_pkg::B_FIRST: begin
                w_emit      = 1'b1;
                w_emit_full = r_flags.first_full;
                w_emit_done = r_flags.first_done;
                if (r_flags.first_full) begin
                    w_emit_avg = cma_pkg::DATA_W'(w_avg_sw);
                end
                if (w_can_load) begin
                    n_state = (r_trail != '0) ? cma_pkg::B_TRAIL : cma_pkg::B_IDLE;
                end
            end
            cma_pkg::B_TRAIL: begin
                w_emit      = 1'b1;
                w_emit_done = (r_trail == AW'(1));
                if (w_can_load && (r_trail == AW'(1))) begin
                    n_state = cma_pkg::B_IDLE;
                end
            end
            default: begin
                n_state = cma_pkg::B_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= cma_pkg::B_IDLE;
            o_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_can_load) begin
                o_out_valid <= w_emit;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_can_load && w_emit) begin
            o_average     <= w_emit_avg;
            o_window_full <= w_emit_full;
            o_stream_done <= w_emit_done;
        end
        if (o_pop) begin
            r_neg   <= i_cmd_total[TW-1];
            r_quo   <= i_cmd_total[TW-1] ? (~i_cmd_total + 1'b1) : i_cmd_total;
            r_rem   <= '0;
            r_div   <= i_cmd_size;
            r_cnt   <= CW'(TW);
            r_trail <= i_cmd_trail;
            r_flags <= i_cmd_flags;
        end else if (r_state == cma_pkg::B_DIVIDE) begin
            r_quo <= {r_quo[TW-2:0], w_ge};
            r_rem <= w_rem_next;
            r_cnt <= r_cnt - 1'b1;
        end else if ((r_state == cma_pkg::B_TRAIL) && w_can_load) begin
            r_trail <= r_trail - 1'b1;
        end
    end

endmodule

`default_nettype wire

@@ src/cma_checker.sv @@
// Port-level checks for the centered moving average, bound to the top level.
// Depends on cma_pkg and on the port list of centered_moving_average.
`default_nettype none

module cma_checker (
    input wire logic                       i_clk,
    input wire logic                       i_rst_n,
    input wire logic                       i_in_valid,
    input wire logic                       o_in_ready,
    input wire logic                       o_out_valid,
    input wire logic                       i_out_ready,
    input wire logic [cma_pkg::DATA_W-1:0] o_average,
    input wire logic                       o_window_full,
    input wire logic                       o_stream_done,
    input wire logic                       i_cfg_valid,
    input wire logic                       o_cfg_ready
);

    // A result word stays offered until it is taken.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("result word dropped before it was taken");

    // A stalled result word keeps its payload.
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=>
            $stable(o_average) && $stable(o_window_full) && $stable(o_stream_done))
        else $error("stalled result word changed");

    // A centre without a full window always reports minus one.
    a_edge_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_window_full |-> o_average == '1)
        else $error("edge result is not minus one");

    // A radius write and a sample are never taken in the same cycle.
    a_cfg_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_cfg_valid && o_cfg_ready && i_in_valid && o_in_ready))
        else $error("radius write and sample taken together");

    // Reset leaves no result word pending.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result word valid right after reset");

endmodule

bind centered_moving_average cma_checker u_cma_checker (.*);

`default_nettype wire
